// ----- sv/pcd_pkg.sv -----
// pcd_pkg: shared types and constants of the chunk deframer
// used by pcd_front, pcd_queue, pcd_back and png_chunk_deframer
package pcd_pkg;

  localparam int unsigned SIGNATURE_BYTES = 8;
  localparam int unsigned FIELD_BYTES     = 4;
  localparam int unsigned HDR_BYTES       = 13;
  localparam int unsigned HDR_IDX_W       = $clog2(HDR_BYTES);
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } phase_e;

  localparam phase_e PHASE_RESET = (SIGNATURE_BYTES == 0) ? PH_LEN : PH_SIG;

  typedef enum logic [1:0] {
    CMD_DATA     = 2'd0,
    CMD_DONE     = 2'd1,
    CMD_DONE_HDR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_HEADER = 2'd2
  } kind_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [7:0]           data_byte;
    logic [31:0]          chunk_type;
    logic [31:0]          chunk_length;
    logic [31:0]          chunk_crc;
    logic [12:0][7:0]     hdr;
  } entry_t;

endpackage

// ----- sv/pcd_front.sv -----
// pcd_front: byte parser; tracks signature/length/type/data/crc phases
// and pushes one command per result-producing byte. uses pcd_pkg
module pcd_front import pcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        push_o,
  output entry_t      entry_o
);

  phase_e             phase_q, phase_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [31:0]        len_q, len_d;
  logic [31:0]        type_q, type_d;
  logic [31:0]        crc_q, crc_d;
  logic [12:0][7:0]   hdr_q, hdr_d;
  logic               first_q, first_d;

  logic [31:0]        cnt_inc;
  logic [31:0]        crc_word;
  logic               sig_done, field_done, data_done;

  assign cnt_inc    = cnt_q + 32'd1;
  assign crc_word   = {crc_q[23:0], file_byte_i};
  assign sig_done   = cnt_inc >= 32'(SIGNATURE_BYTES);
  assign field_done = cnt_inc == 32'(FIELD_BYTES);
  assign data_done  = cnt_inc == len_q;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_SIG:  if (sig_done) phase_d = PH_LEN;
        PH_LEN:  if (field_done) phase_d = PH_TYPE;
        PH_TYPE: if (field_done) phase_d = (len_q == 32'd0) ? PH_CRC : PH_DATA;
        PH_DATA: if (data_done) phase_d = PH_CRC;
        PH_CRC:  if (field_done) phase_d = PH_LEN;
        default: phase_d = PHASE_RESET;
      endcase
      if (end_of_file_i) phase_d = PHASE_RESET;
    end
  end

  // field assembly and command generation
  always_comb begin
    cnt_d   = cnt_q;
    len_d   = len_q;
    type_d  = type_q;
    crc_d   = crc_q;
    hdr_d   = hdr_q;
    first_d = first_q;
    push_o  = 1'b0;
    entry_o.cmd          = CMD_DATA;
    entry_o.data_byte    = 8'd0;
    entry_o.chunk_type   = type_q;
    entry_o.chunk_length = len_q;
    entry_o.chunk_crc    = 32'd0;
    entry_o.hdr          = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_SIG: begin
          cnt_d = sig_done ? 32'd0 : cnt_inc;
        end
        PH_LEN: begin
          len_d = {len_q[23:0], file_byte_i};
          cnt_d = field_done ? 32'd0 : cnt_inc;
        end
        PH_TYPE: begin
          type_d = {type_q[23:0], file_byte_i};
          cnt_d  = field_done ? 32'd0 : cnt_inc;
          if (field_done) crc_d = 32'd0;
        end
        PH_DATA: begin
          if (first_q && cnt_q < 32'(HDR_BYTES)) hdr_d[cnt_q[HDR_IDX_W-1:0]] = file_byte_i;
          push_o            = 1'b1;
          entry_o.data_byte = file_byte_i;
          cnt_d = data_done ? 32'd0 : cnt_inc;
        end
        PH_CRC: begin
          crc_d = crc_word;
          cnt_d = field_done ? 32'd0 : cnt_inc;
          if (field_done) begin
            push_o            = 1'b1;
            entry_o.cmd       = first_q ? CMD_DONE_HDR : CMD_DONE;
            entry_o.chunk_crc = crc_word;
            entry_o.hdr       = hdr_q;
            first_d           = 1'b0;
          end
        end
        default: begin
          cnt_d   = 32'd0;
          len_d   = 32'd0;
          type_d  = 32'd0;
          crc_d   = 32'd0;
          hdr_d   = '0;
          first_d = 1'b1;
        end
      endcase
      // end of file restarts the parser once this byte is handled
      if (end_of_file_i) begin
        cnt_d   = 32'd0;
        len_d   = 32'd0;
        type_d  = 32'd0;
        crc_d   = 32'd0;
        hdr_d   = '0;
        first_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_RESET;
      cnt_q   <= 32'd0;
      len_q   <= 32'd0;
      type_q  <= 32'd0;
      crc_q   <= 32'd0;
      hdr_q   <= '0;
      first_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      type_q  <= type_d;
      crc_q   <= crc_d;
      hdr_q   <= hdr_d;
      first_q <= first_d;
    end
  end

endmodule

// ----- sv/pcd_queue.sv -----
// pcd_queue: short command queue between parser and result sequencer
// uses pcd_pkg for the entry type and depth
module pcd_queue import pcd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   not_empty_o,
  output logic   full_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o      = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign not_empty_o = cnt_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

// ----- sv/pcd_back.sv -----
// pcd_back: expands queued commands into result items and holds them
// in the output register. uses pcd_pkg
module pcd_back import pcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        not_empty_i,
  output logic        pop_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] chunk_type_o,
  output logic [31:0] chunk_length_o,
  output logic [31:0] chunk_crc_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o,
  output logic [7:0]  bit_depth_o,
  output logic [7:0]  color_type_o,
  output logic [7:0]  compression_method_o,
  output logic [7:0]  filter_method_o,
  output logic [7:0]  interlace_method_o
);

  logic        valid_q, valid_d;
  logic        second_q, second_d;
  logic        load, take, hdr_beat;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q;
  logic [31:0] type_q, len_q, crc_q, width_q, height_q;
  logic [7:0]  depth_q, color_q, compr_q, filt_q, inter_q;

  assign load     = !valid_q || !out_stall_i;
  assign take     = load && not_empty_i;
  // a done-with-header command gives the complete result first, then the header
  assign hdr_beat = second_q;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    pop_o    = 1'b0;
    kind_d   = KIND_DATA;
    unique case (head_i.cmd)
      CMD_DATA:     kind_d = KIND_DATA;
      CMD_DONE:     kind_d = KIND_DONE;
      CMD_DONE_HDR: kind_d = hdr_beat ? KIND_HEADER : KIND_DONE;
      default:      kind_d = KIND_DATA;
    endcase
    if (load) valid_d = take;
    if (take) begin
      if (head_i.cmd == CMD_DONE_HDR && !second_q) begin
        second_d = 1'b1;
      end else begin
        second_d = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind_d;
      data_q <= head_i.data_byte;
      type_q <= head_i.chunk_type;
      len_q  <= head_i.chunk_length;
      crc_q  <= head_i.chunk_crc;
      if (hdr_beat) begin
        width_q  <= {head_i.hdr[0], head_i.hdr[1], head_i.hdr[2], head_i.hdr[3]};
        height_q <= {head_i.hdr[4], head_i.hdr[5], head_i.hdr[6], head_i.hdr[7]};
        depth_q  <= head_i.hdr[8];
        color_q  <= head_i.hdr[9];
        compr_q  <= head_i.hdr[10];
        filt_q   <= head_i.hdr[11];
        inter_q  <= head_i.hdr[12];
      end else begin
        width_q  <= 32'd0;
        height_q <= 32'd0;
        depth_q  <= 8'd0;
        color_q  <= 8'd0;
        compr_q  <= 8'd0;
        filt_q   <= 8'd0;
        inter_q  <= 8'd0;
      end
    end
  end

  assign out_valid_o          = valid_q;
  assign result_kind_o        = kind_q;
  assign data_byte_o          = data_q;
  assign chunk_type_o         = type_q;
  assign chunk_length_o       = len_q;
  assign chunk_crc_o          = crc_q;
  assign image_width_o        = width_q;
  assign image_height_o       = height_q;
  assign bit_depth_o          = depth_q;
  assign color_type_o         = color_q;
  assign compression_method_o = compr_q;
  assign filter_method_o      = filt_q;
  assign interlace_method_o   = inter_q;

endmodule

// ----- sv/png_chunk_deframer.sv -----
// png_chunk_deframer: top level, parser front, command queue, result back end
// depends on pcd_pkg, pcd_front, pcd_queue, pcd_back
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i, in_stall_o, file_byte_i, end_of_file_i     | request in
//   out     | out_valid_o, out_stall_i, result_kind_o .. interlace_method_o | request out
//
// one byte is taken per cycle while the queue is not full; a data byte leaves
// through the queue and the output register. the end of the first chunk gives
// two results, which the back end sends one after another from one queue entry,
// so that byte holds its queue space until both are sent. in_stall_o rises only
// when the two-entry queue is full. reset clears all parser state; the next byte
// is taken as a signature byte.
module png_chunk_deframer import pcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] chunk_type_o,
  output logic [31:0] chunk_length_o,
  output logic [31:0] chunk_crc_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o,
  output logic [7:0]  bit_depth_o,
  output logic [7:0]  color_type_o,
  output logic [7:0]  compression_method_o,
  output logic [7:0]  filter_method_o,
  output logic [7:0]  interlace_method_o
);

  logic   accept;
  logic   push, pop, full, not_empty;
  entry_t push_entry, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  pcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .file_byte_i   (file_byte_i),
    .end_of_file_i (end_of_file_i),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  pcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .not_empty_o  (not_empty),
    .full_o       (full)
  );

  pcd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_i               (head),
    .not_empty_i          (not_empty),
    .pop_o                (pop),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .result_kind_o        (result_kind_o),
    .data_byte_o          (data_byte_o),
    .chunk_type_o         (chunk_type_o),
    .chunk_length_o       (chunk_length_o),
    .chunk_crc_o          (chunk_crc_o),
    .image_width_o        (image_width_o),
    .image_height_o       (image_height_o),
    .bit_depth_o          (bit_depth_o),
    .color_type_o         (color_type_o),
    .compression_method_o (compression_method_o),
    .filter_method_o      (filter_method_o),
    .interlace_method_o   (interlace_method_o)
  );

endmodule

// ----- tb/tb_png_chunk_deframer.sv -----
`timescale 1ns / 1ps
// tb_png_chunk_deframer: self-checking bench for the chunk deframer, byte stream in, results out
// depends on pcd_pkg and png_chunk_deframer; expected results come from a byte-level parser model

module tb_png_chunk_deframer;
  import pcd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] chunk_crc;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  bit_depth;
    logic [7:0]  color_type;
    logic [7:0]  compression_method;
    logic [7:0]  filter_method;
    logic [7:0]  interlace_method;
  } chunk_result_t;

  class chunk_scoreboard;
    phase_e        phase;
    int unsigned   count;
    logic [31:0]   len_word;
    logic [31:0]   type_word;
    logic [31:0]   crc_word;
    logic [7:0]    hdr [HDR_BYTES];
    bit            first_chunk;
    chunk_result_t results_due[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   data_seen;
    int unsigned   ends_seen;
    int unsigned   headers_seen;
    int unsigned   restarts;

    function new();
      restart();
    endfunction

    function void restart();
      phase = PHASE_RESET;
      count = 0;
      len_word = '0;
      type_word = '0;
      crc_word = '0;
      foreach (hdr[i]) hdr[i] = 8'h00;
      first_chunk = 1'b1;
    endfunction

    function void queue_result(chunk_result_t r);
      results_due = {results_due, r};
    endfunction

    function chunk_result_t form_result(kind_e k, logic [7:0] b, logic [31:0] crc_w,
                                        bit with_hdr);
      chunk_result_t r;
      r = '0;
      r.kind = k;
      r.data_byte = b;
      r.chunk_type = type_word;
      r.chunk_length = len_word;
      r.chunk_crc = crc_w;
      if (with_hdr) begin
        r.image_width = {hdr[0], hdr[1], hdr[2], hdr[3]};
        r.image_height = {hdr[4], hdr[5], hdr[6], hdr[7]};
        r.bit_depth = hdr[8];
        r.color_type = hdr[9];
        r.compression_method = hdr[10];
        r.filter_method = hdr[11];
        r.interlace_method = hdr[12];
      end
      return r;
    endfunction

    // one accepted request: advance the parser and queue what it produces
    function void deframe_byte(logic [7:0] b, logic eof);
      case (phase)
        PH_SIG: begin
          count++;
          if (count >= SIGNATURE_BYTES) begin
            phase = PH_LEN;
            count = 0;
          end
        end
        PH_LEN: begin
          len_word = {len_word[23:0], b};
          count++;
          if (count == FIELD_BYTES) begin
            phase = PH_TYPE;
            count = 0;
          end
        end
        PH_TYPE: begin
          type_word = {type_word[23:0], b};
          count++;
          if (count == FIELD_BYTES) begin
            phase = (len_word == 32'd0) ? PH_CRC : PH_DATA;
            count = 0;
            crc_word = '0;
          end
        end
        PH_DATA: begin
          if (first_chunk && count < HDR_BYTES) hdr[count] = b;
          queue_result(form_result(KIND_DATA, b, 32'd0, 1'b0));
          count++;
          if (count == len_word) begin
            phase = PH_CRC;
            count = 0;
          end
        end
        PH_CRC: begin
          crc_word = {crc_word[23:0], b};
          count++;
          if (count == FIELD_BYTES) begin
            queue_result(form_result(KIND_DONE, 8'h00, crc_word, 1'b0));
            if (first_chunk) begin
              queue_result(form_result(KIND_HEADER, 8'h00, crc_word, 1'b1));
              first_chunk = 1'b0;
            end
            phase = PH_LEN;
            count = 0;
          end
        end
        default: restart();
      endcase
      if (eof) begin
        restart();
        restarts++;
      end
    endfunction

    function string describe(chunk_result_t r);
      return $sformatf({"kind %0d byte %02h type %08h len %08h crc %08h w %08h h %08h",
                        " depth %02h color %02h comp %02h filt %02h intl %02h"},
                       r.kind, r.data_byte, r.chunk_type, r.chunk_length, r.chunk_crc,
                       r.image_width, r.image_height, r.bit_depth, r.color_type,
                       r.compression_method, r.filter_method, r.interlace_method);
    endfunction

    function void check_result(chunk_result_t got);
      chunk_result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = results_due.pop_front();
      checked++;
      case (got.kind)
        KIND_DATA:   data_seen++;
        KIND_DONE:   ends_seen++;
        KIND_HEADER: headers_seen++;
        default: ;
      endcase
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  file_byte_i = 8'h00;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  data_byte_o;
  logic [31:0] chunk_type_o;
  logic [31:0] chunk_length_o;
  logic [31:0] chunk_crc_o;
  logic [31:0] image_width_o;
  logic [31:0] image_height_o;
  logic [7:0]  bit_depth_o;
  logic [7:0]  color_type_o;
  logic [7:0]  compression_method_o;
  logic [7:0]  filter_method_o;
  logic [7:0]  interlace_method_o;

  chunk_scoreboard sb = new();
  logic [7:0]      file_q[$];
  bit              quiet = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     stall_cycles = 0;

  png_chunk_deframer dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .file_byte_i          (file_byte_i),
    .end_of_file_i        (end_of_file_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .result_kind_o        (result_kind_o),
    .data_byte_o          (data_byte_o),
    .chunk_type_o         (chunk_type_o),
    .chunk_length_o       (chunk_length_o),
    .chunk_crc_o          (chunk_crc_o),
    .image_width_o        (image_width_o),
    .image_height_o       (image_height_o),
    .bit_depth_o          (bit_depth_o),
    .color_type_o         (color_type_o),
    .compression_method_o (compression_method_o),
    .filter_method_o      (filter_method_o),
    .interlace_method_o   (interlace_method_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_byte(logic [7:0] b);
    file_q = {file_q, b};
  endfunction

  function automatic void push_word(logic [31:0] w);
    add_byte(w[31:24]);
    add_byte(w[23:16]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endfunction

  // signature content is never checked, so random bytes do
  function automatic void push_signature();
    for (int unsigned i = 0; i < SIGNATURE_BYTES; i++) add_byte(8'($urandom));
  endfunction

  function automatic void push_chunk(logic [31:0] len, logic [31:0] tag);
    push_word(len);
    push_word(tag);
    for (int unsigned i = 0; i < len; i++) add_byte(8'($urandom));
    push_word($urandom);
  endfunction

  function automatic void build_file();
    int unsigned n_chunks;
    logic [31:0] len;
    logic [31:0] tag;
    n_chunks = $urandom_range(1, 4);
    push_signature();
    for (int unsigned c = 0; c < n_chunks; c++) begin
      if (c == 0) begin
        // first chunk: empty, short, exact and long header payloads
        case ($urandom_range(0, 3))
          0:       len = 32'd0;
          1:       len = $urandom_range(1, HDR_BYTES - 1);
          2:       len = HDR_BYTES;
          default: len = $urandom_range(HDR_BYTES + 1, 30);
        endcase
        tag = ($urandom_range(0, 1) == 0) ? 32'h49484452 : $urandom;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 20);
        tag = $urandom;
      end
      push_chunk(len, tag);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    file_byte_i <= b;
    end_of_file_i <= eof;
    @(posedge clk_i);
    while (in_stall_o) begin
      stall_cycles++;
      @(posedge clk_i);
    end
    sb.deframe_byte(b, eof);
    items_sent++;
  endtask

  // sends the first cut bytes of the built file, end of file on the last one if close is set
  task automatic play_file(input int unsigned cut, input bit close);
    for (int unsigned i = 0; i < cut; i++) send_byte(file_q[i], close && (i == cut - 1));
    file_q.delete();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({result_kind_o, data_byte_o, chunk_type_o, chunk_length_o, chunk_crc_o,
                       image_width_o, image_height_o, bit_depth_o, color_type_o,
                       compression_method_o, filter_method_o, interlace_method_o});
  end

  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!held && sb.checked >= 200) begin
        // long hold-off so the queue fills and the input side backs up
        held = 1'b1;
        hold_left = 120;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 15);
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned cut;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty first chunk ending the file on its last crc byte: header reads all zero
    push_signature();
    push_chunk(32'd0, 32'h49484452);
    play_file(file_q.size(), 1'b1);
    // end of file inside the signature
    push_signature();
    play_file(4, 1'b1);

    while (items_sent < 1400) begin
      quiet = (items_sent >= 600) && (items_sent < 800);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        build_file();
        cut = file_q.size();
        if (pick >= 70) cut = $urandom_range(1, file_q.size());
        play_file(cut, 1'b1);
      end else if (pick < 93) begin
        // huge declared length, cut short by end of file
        push_signature();
        push_word($urandom);
        push_word($urandom);
        repeat ($urandom_range(0, 20)) add_byte(8'($urandom));
        play_file(file_q.size(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 16)) add_byte(8'($urandom));
        play_file(file_q.size(), $urandom_range(0, 1));
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("sent %0d file bytes with %0d end-of-file restarts, input held off %0d cycles",
             items_sent, sb.restarts, stall_cycles);
    $display("checked %0d results: %0d payload bytes, %0d chunk ends, %0d header decodes",
             sb.checked, sb.data_seen, sb.ends_seen, sb.headers_seen);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("png_chunk_deframer test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.results_due.size());
      $display("png_chunk_deframer test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.results_due.size());
    $display("png_chunk_deframer test failed");
    $finish;
  end

endmodule
